// File: rtl/csrspmv_pkg.sv
// Shared types, constants and saturating arithmetic for the CSR SpMV residual engine.
`timescale 1ns / 1ps

package csrspmv_pkg;

    // Default sizes
    localparam int unsigned VECTOR_DEPTH_DEF  = 1024;
    localparam logic [32:0] ROW_COUNT_MAX_DEF = 33'd65536;

    // Field widths
    localparam int unsigned COL_W   = 10;
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned ROW_W   = 16;
    localparam int unsigned ACC_W   = 64;
    localparam int unsigned CCNT_W  = 11;
    localparam int unsigned CIDX_W  = 1;
    localparam int unsigned IDATA_W = 80;
    localparam int unsigned ODATA_W = 48;

    // Configuration register indexes and the column count reset value
    localparam logic [CIDX_W-1:0] CFG_RESIDUAL_MODE = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_COLUMN_COUNT  = 1'b1;
    localparam logic [CCNT_W-1:0] COLUMN_COUNT_RST  = 11'd1024;

    // Rounding constant: half an LSB of a Q16.16 result, in Q32.32
    localparam logic signed [ACC_W-1:0] ROUND_HALF = 64'sd32768;

    // Request kinds
    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_ENTRY = 2'd1,
        REQ_EMPTY = 2'd2
    } t_req;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SAT   = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // Saturated 64-bit value with its overflow flag
    typedef struct packed {
        logic signed [ACC_W-1:0] value;
        logic                    sat;
    } t_sat64;

    // a + b clamped to the signed 64-bit range
    function automatic t_sat64 add_sat64(input logic signed [ACC_W-1:0] a,
                                         input logic signed [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        t_sat64         r;
        s     = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        r.sat = s[ACC_W] ^ s[ACC_W-1];
        if (r.sat) begin
            r.value = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            r.value = s[ACC_W-1:0];
        end
        return r;
    endfunction

    // a - b clamped to the signed 64-bit range
    function automatic t_sat64 sub_sat64(input logic signed [ACC_W-1:0] a,
                                         input logic signed [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        t_sat64         r;
        s     = {a[ACC_W-1], a} - {b[ACC_W-1], b};
        r.sat = s[ACC_W] ^ s[ACC_W-1];
        if (r.sat) begin
            r.value = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            r.value = s[ACC_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/csr_spmv_residual_engine_unit.sv
// CSR sparse matrix-vector product engine with residual mode, top level.
// A row result passes the stage 1, 2, 4 and 5 registers and the output register to m_axis.
// Throughput: one request per cycle unless m_axis stalls; loads, entries and row ends may
// follow back to back. Rate is set by the x store (one write and one registered read per
// cycle) and the five-stage read, multiply, accumulate, residual and rounding pipeline.
// Reset clears pipeline valids, accumulator, row counter and row error and presets the
// config registers; the x store is not cleared and holds garbage until loaded.
`timescale 1ns / 1ps

module csr_spmv_residual_engine_unit #(
    parameter int unsigned VECTOR_DEPTH  = csrspmv_pkg::VECTOR_DEPTH_DEF,
    parameter logic [32:0] ROW_COUNT_MAX = csrspmv_pkg::ROW_COUNT_MAX_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [csrspmv_pkg::CIDX_W-1:0]      i_cfg_index,
    input  logic [csrspmv_pkg::CCNT_W-1:0]      i_cfg_data,
    // request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [9:0] col_index, [41:10] element_value, [73:42] rhs_value, [79:74] zero
    input  logic [csrspmv_pkg::IDATA_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tlast,   // row_last
    input  logic [1:0]                          s_axis_tuser,   // [1:0] req_type
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] result_value, [47:32] row_number
    output logic [csrspmv_pkg::ODATA_W-1:0]     m_axis_tdata,
    output logic [1:0]                          m_axis_tuser    // [1:0] status
);
    import csrspmv_pkg::*;

    localparam int unsigned AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
    localparam int unsigned XW = 17;

    // configuration registers
    logic              r_mode;
    logic [CCNT_W-1:0] r_col_count;

    // x store
    logic [VAL_W-1:0]  r_xmem [VECTOR_DEPTH];

    // stage valids
    logic r_v1, r_v2, r_v4, r_v5, r_ov;

    // stage 1: request fields and x read
    logic                    r1_entry, r1_ok, r1_last;
    logic signed [VAL_W-1:0] r1_val, r1_x, r1_rhs;

    // stage 2: product
    logic                    r2_entry, r2_ok, r2_last;
    logic signed [ACC_W-1:0] r2_prod;
    logic signed [VAL_W-1:0] r2_rhs;

    // row state
    logic signed [ACC_W-1:0] r_acc;
    t_status                 r_err;
    logic [ROW_W-1:0]        r_row;

    // stage 4: closed row
    logic signed [ACC_W-1:0] r4_sum;
    logic signed [VAL_W-1:0] r4_rhs;
    t_status                 r4_err;
    logic [ROW_W-1:0]        r4_row;
    logic                    r4_mode;

    // stage 5: value before rounding
    logic signed [ACC_W-1:0] r5_val;
    logic                    r5_sat;
    t_status                 r5_err;
    logic [ROW_W-1:0]        r5_row;

    // output register
    logic [VAL_W-1:0]        r_o_result;
    logic [ROW_W-1:0]        r_o_row;
    t_status                 r_o_status;

    // input decode
    t_req             in_req;
    logic [COL_W-1:0] in_col;
    logic [XW-1:0]    in_col_ext;
    logic [AW-1:0]    in_addr;
    logic             in_depth_ok, in_col_ok, in_keep, in_load, in_accept;

    // flow control
    logic out_rdy, rdy5, rdy4, rdy2, rdy1, en2, en3, en4, en5;

    // stage 3 logic
    logic                    close3;
    logic signed [ACC_W-1:0] addend3;
    t_sat64                  sum3;
    t_status                 n_err;
    logic [ROW_W:0]          row_inc;
    logic [ROW_W-1:0]        n_row;

    // stage 4 / 5 logic
    t_sat64                  res4;
    t_sat64                  rnd5;
    logic signed [ACC_W-17:0] q5;
    logic                    clamp5;
    logic [VAL_W-1:0]        val5;
    t_status                 status5;

    // decode the request
    assign in_req      = t_req'(s_axis_tuser);
    assign in_col      = s_axis_tdata[COL_W-1:0];
    assign in_col_ext  = {{(XW-COL_W){1'b0}}, in_col};
    assign in_addr     = in_col_ext[AW-1:0];
    assign in_depth_ok = in_col_ext < XW'(VECTOR_DEPTH);
    assign in_col_ok   = in_depth_ok && ({1'b0, in_col} < r_col_count);
    assign in_accept   = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_keep = 1'b0;
        in_load = 1'b0;
        unique case (in_req)
            REQ_LOAD:  in_load = 1'b1;
            REQ_ENTRY: in_keep = 1'b1;
            REQ_EMPTY: in_keep = 1'b1;
            default:   in_keep = 1'b0;
        endcase
    end

    // backpressure chain from the output register back to the input
    assign out_rdy = !r_ov || m_axis_tready;
    assign rdy5    = !r_v5 || out_rdy;
    assign rdy4    = !r_v4 || rdy5;
    assign rdy2    = !r_v2 || rdy4;
    assign rdy1    = !r_v1 || rdy2;
    assign s_axis_tready = rdy1;
    assign en2 = r_v1 && rdy2;
    assign en3 = r_v2 && rdy4;
    assign en4 = r_v4 && rdy5;
    assign en5 = r_v5 && out_rdy;

    // accumulate: add the product unless the entry is out of range or the row is empty
    assign close3  = !r2_entry || r2_last;
    assign addend3 = (r2_entry && r2_ok) ? r2_prod : '0;
    assign sum3    = add_sat64(r_acc, addend3);

    always_comb begin
        n_err = r_err;
        if (r2_entry && !r2_ok) begin
            n_err = ST_RANGE;
        end else if (sum3.sat && r_err == ST_OK) begin
            n_err = ST_SAT;
        end
    end

    // advance the row number, wrap at the row limit
    assign row_inc = {1'b0, r_row} + 17'd1;
    assign n_row   = ({16'b0, row_inc} >= ROW_COUNT_MAX) ? '0 : row_inc[ROW_W-1:0];

    // residual: b in Q32.32 minus the row sum
    assign res4 = r4_mode ? sub_sat64({{16{r4_rhs[VAL_W-1]}}, r4_rhs, 16'b0}, r4_sum)
                          : t_sat64'{value: r4_sum, sat: 1'b0};

    // round to Q16.16 with floor shift, clamp to 32 bits
    assign rnd5   = add_sat64(r5_val, ROUND_HALF);
    assign q5     = rnd5.value[ACC_W-1:16];
    assign clamp5 = !((&q5[ACC_W-17:VAL_W-1]) || !(|q5[ACC_W-17:VAL_W-1]));
    assign val5   = clamp5 ? (q5[ACC_W-17] ? {1'b1, {(VAL_W-1){1'b0}}}
                                           : {1'b0, {(VAL_W-1){1'b1}}})
                           : q5[VAL_W-1:0];

    always_comb begin
        if (r5_err == ST_RANGE) begin
            status5 = ST_RANGE;
        end else if (r5_err == ST_SAT || r5_sat || rnd5.sat || clamp5) begin
            status5 = ST_SAT;
        end else begin
            status5 = ST_OK;
        end
    end

    // write loads into the x store, read it for every request
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            if (in_load && in_depth_ok) begin
                r_xmem[in_addr] <= s_axis_tdata[COL_W +: VAL_W];
            end
            r1_x <= r_xmem[in_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_col_count <= COLUMN_COUNT_RST;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_ov        <= 1'b0;
            r_acc       <= '0;
            r_err       <= ST_OK;
            r_row       <= '0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_RESIDUAL_MODE: r_mode      <= i_cfg_data[0];
                    CFG_COLUMN_COUNT:  r_col_count <= i_cfg_data;
                    default:           r_mode      <= r_mode;
                endcase
            end
            // stage valids
            if (rdy1) begin
                r_v1 <= in_accept && in_keep;
            end
            if (rdy2) begin
                r_v2 <= en2;
            end
            if (rdy4) begin
                r_v4 <= en3 && close3;
            end
            if (rdy5) begin
                r_v5 <= en4;
            end
            if (out_rdy) begin
                r_ov <= en5;
            end
            // row state: hold the running sum, drop it at the row end
            if (en3) begin
                if (close3) begin
                    r_acc <= '0;
                    r_err <= ST_OK;
                    r_row <= n_row;
                end else begin
                    r_acc <= sum3.value;
                    r_err <= n_err;
                end
            end
        end
    end

    // payload pipeline
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r1_entry <= (in_req == REQ_ENTRY);
            r1_ok    <= in_col_ok;
            r1_last  <= s_axis_tlast;
            r1_val   <= s_axis_tdata[COL_W +: VAL_W];
            r1_rhs   <= s_axis_tdata[COL_W+VAL_W +: VAL_W];
        end
        if (en2) begin
            r2_entry <= r1_entry;
            r2_ok    <= r1_ok;
            r2_last  <= r1_last;
            r2_prod  <= r1_val * r1_x;
            r2_rhs   <= r1_rhs;
        end
        if (en3 && close3) begin
            r4_sum  <= sum3.value;
            r4_rhs  <= r2_rhs;
            r4_err  <= n_err;
            r4_row  <= r_row;
            r4_mode <= r_mode;
        end
        if (en4) begin
            r5_val <= res4.value;
            r5_sat <= res4.sat;
            r5_err <= r4_err;
            r5_row <= r4_row;
        end
        if (en5) begin
            r_o_result <= val5;
            r_o_row    <= r5_row;
            r_o_status <= status5;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {r_o_row, r_o_result};
    assign m_axis_tuser  = r_o_status;

    // ready only drops while the first stage is occupied
    a_ready_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_v1)
        else $error("input stalled with an empty first stage");

    // a closed row leaves a clean accumulator and error
    a_row_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en3 && close3 |=> r_acc == '0 && r_err == ST_OK)
        else $error("row state not cleared after row end");

    // an out-of-range entry inside a row marks the row
    a_range_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en3 && r2_entry && !r2_ok && !close3 |=> r_err == ST_RANGE)
        else $error("out-of-range column not flagged");

    // every row end moves the row counter unless the limit is one row
    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en3 && close3 && ROW_COUNT_MAX != 33'd1 |=> r_row != $past(r_row))
        else $error("row counter did not advance");

endmodule
